### design/gbn_pkg.sv
`default_nettype none
package gbn_pkg;
  localparam int DefMaxWindow = 16;
  localparam int DefSizeBits = 24;
  localparam int DefMaxPayload = 4096;

  typedef enum logic [1:0] {OP_START = 2'd0, OP_TICK = 2'd1, OP_CANCEL = 2'd2} op_t;
  typedef enum logic [2:0] {
    CFG_WINDOW = 3'd0, CFG_TIMEOUT = 3'd1, CFG_BUDGET = 3'd2,
    CFG_PAYLOAD = 3'd3, CFG_MAXFILE = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] LINK_OK = 2'd0;
  localparam logic [1:0] LINK_POLL_TO = 2'd1;
  localparam logic [1:0] LINK_SEND_FAIL = 2'd3;

  localparam logic [3:0] FR_NONE = 4'd0;
  localparam logic [3:0] FR_ABORTED = 4'd4;
  localparam logic [3:0] FR_CANCELLED = 4'd5;
  localparam logic [3:0] FR_IO = 4'd6;
  localparam logic [3:0] FR_RETRY = 4'd9;

  localparam logic [1:0] RS_OK = 2'd0;
  localparam logic [1:0] RS_BUSY = 2'd1;
  localparam logic [1:0] RS_ERR = 2'd2;

  localparam logic [2:0] RES_NO_PROGRESS = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SEND_NEW, ST_ACK, ST_RESEND, ST_STATUS
  } state_t;

  function automatic logic [1:0] map_status(input logic [2:0] code);
    return (code == 3'd0) ? RS_OK : ((code == 3'd1) ? RS_BUSY : RS_ERR);
  endfunction
endpackage
`default_nettype wire

### design/gbn_if.sv
`default_nettype none
interface gbn_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/gbn_front.sv
`default_nettype none
// Accepts input beats and holds them in a two-entry queue for the engine.
module gbn_front import gbn_pkg::*; #(
  parameter int IW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [IW-1:0] in_data,
  output logic               q_valid,
  input  wire logic          q_take,
  output logic [IW-1:0]      q_data
);
  logic [IW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_take && q_valid) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

### design/gbn_engine.sv
`default_nettype none
// Transfer state and sequencer. One result beat leaves per cycle at most.
module gbn_engine import gbn_pkg::*; #(
  parameter int MAX_WINDOW = DefMaxWindow,
  parameter int SIZE_BITS = DefSizeBits,
  parameter int MAX_PAYLOAD = DefMaxPayload
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        q_valid,
  output logic             q_take,
  input  wire logic [1:0]  i_op,
  input  wire logic [31:0] i_ctx,
  input  wire logic [23:0] i_fsize,
  input  wire logic        i_range,
  input  wire logic [1:0]  i_link,
  input  wire logic [2:0]  i_ares,
  input  wire logic [23:0] i_acont,
  input  wire logic [23:0] i_acomm,
  input  wire logic [31:0] i_adup,
  input  wire logic        i_cok,
  input  wire logic [2:0]  i_cres,
  input  wire logic        i_abort,
  output logic             o_valid,
  input  wire logic        o_ready,
  output logic             o_kind,
  output logic [23:0]      o_seg,
  output logic [23:0]      o_off,
  output logic [12:0]      o_len,
  output logic             o_fin,
  output logic [3:0]       o_fres,
  output logic [1:0]       o_rs,
  output logic [31:0]      o_ctx,
  output logic             o_prog,
  output logic             o_dup,
  output logic             o_rsd
);
  localparam int SB = SIZE_BITS;
  localparam int PB = $clog2(MAX_PAYLOAD + 1);
  localparam int WB = $clog2(MAX_WINDOW + 1);
  localparam int OB = SB + PB;

  // configuration
  logic [4:0]  win_r;
  logic [15:0] tmo_r;
  logic [7:0]  bud_r;
  logic [12:0] pay_r;
  logic [23:0] maxf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 5'd8; tmo_r <= 16'd10; bud_r <= 8'd3; pay_r <= 13'd256;
      maxf_r <= 24'd1048576;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WINDOW:  win_r <= cfg_wdata[4:0];
        CFG_TIMEOUT: tmo_r <= cfg_wdata[15:0];
        CFG_BUDGET:  bud_r <= cfg_wdata[7:0];
        CFG_PAYLOAD: pay_r <= cfg_wdata[12:0];
        CFG_MAXFILE: maxf_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [PB-1:0] epay;
  logic [WB-1:0] ewin;
  always_comb begin
    if (pay_r == 13'd0) epay = PB'(1);
    else if (32'(pay_r) > 32'(MAX_PAYLOAD)) epay = PB'(MAX_PAYLOAD);
    else epay = PB'(pay_r);
    if (win_r == 5'd0) ewin = WB'(1);
    else if (32'(win_r) > 32'(MAX_WINDOW)) ewin = WB'(MAX_WINDOW);
    else ewin = WB'(win_r);
  end

  // transfer state
  logic          active_r, sending_r;
  logic [31:0]   sctx_r;
  logic [SB-1:0] fsz_r, tot_r, nts_r, ack_r, comm_r;
  logic [31:0]   dcnt_r;
  logic [15:0]   idle_r;
  logic [7:0]    ret_r;
  logic [31:0]   rtot_r;
  logic [3:0]    lout_r;

  // sequencer
  state_t        st_r;
  logic [SB-1:0] cur_r, lim_r;
  logic [SB-1:0] rem_r, quo_r;
  logic [SB:0]   dacc_r;
  logic [5:0]    dstep_r;
  logic          fin_r, prog_r, dup_r, rsd_r;
  logic [3:0]    fres_r;
  logic [1:0]    rs_r;
  logic [31:0]   octx_r;
  // Send command offset, kept at full width so that a segment lying past the
  // file after a payload change is still seen as beyond its end.
  logic [OB-1:0] soff_r;

  logic [SB:0] wlim;
  assign wlim = (SB+1)'(ack_r) + (SB+1)'(ewin);

  // output register
  logic o_full_r;
  logic o_free;
  assign o_free = !o_full_r || o_ready;
  assign o_valid = o_full_r;

  logic [OB-1:0] rem_bytes;
  assign rem_bytes = OB'(fsz_r) - soff_r;

  logic [SB-1:0] ack_n, comm_n, c_in, cm_in;
  logic [31:0]   dp_in;
  logic [2:0]    res_in;
  logic [15:0]   idle_n;
  logic          prog_n;

  always_comb begin
    if (i_link == LINK_POLL_TO) begin
      res_in = RES_NO_PROGRESS; c_in = ack_r; cm_in = comm_r; dp_in = dcnt_r;
    end else begin
      res_in = i_ares; c_in = SB'(i_acont); cm_in = SB'(i_acomm); dp_in = i_adup;
    end
    if (c_in > tot_r) c_in = tot_r;
    ack_n = (c_in > ack_r) ? c_in : ack_r;
    if (cm_in > fsz_r) cm_in = fsz_r;
    comm_n = (cm_in > comm_r) ? cm_in : comm_r;
    prog_n = (res_in == 3'd0) && (ack_n > ack_r);
    if (prog_n) idle_n = 16'd0;
    else if (idle_r != 16'hFFFF) idle_n = idle_r + 16'd1;
    else idle_n = idle_r;
  end

  logic dup_big;
  assign dup_big = i_cok && (i_adup > dcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; o_full_r <= 1'b0;
      active_r <= 1'b0; sending_r <= 1'b0; sctx_r <= '0; fsz_r <= '0; tot_r <= '0;
      nts_r <= '0; ack_r <= '0; comm_r <= '0; dcnt_r <= '0; idle_r <= '0; ret_r <= '0;
      rtot_r <= '0; lout_r <= FR_NONE;
    end else begin
      if (o_full_r && o_ready) o_full_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            fin_r <= 1'b0; fres_r <= FR_NONE; rs_r <= RS_OK; octx_r <= '0;
            prog_r <= 1'b0; dup_r <= 1'b0; rsd_r <= 1'b0;
            st_r <= ST_STATUS;
            case (i_op)
              OP_START: begin
                sctx_r <= i_ctx;
                if (active_r) rs_r <= RS_BUSY;
                else if (i_range) begin
                  rs_r <= RS_ERR; octx_r <= i_ctx;
                end else if (i_fsize > maxf_r) begin
                  rs_r <= RS_ERR; octx_r <= i_ctx;
                  sending_r <= 1'b0; nts_r <= '0; idle_r <= '0; ret_r <= '0;
                end else begin
                  fsz_r <= SB'(i_fsize); octx_r <= i_ctx;
                  nts_r <= '0; idle_r <= '0; ret_r <= '0;
                  ack_r <= '0; comm_r <= '0; rtot_r <= '0; dcnt_r <= '0;
                  lout_r <= FR_NONE;
                  if (!i_cok) begin
                    rs_r <= RS_ERR; sending_r <= 1'b0; active_r <= 1'b0;
                  end else if (i_cres != 3'd0) begin
                    fres_r <= {1'b0, i_cres} + 4'd1; rs_r <= map_status(i_cres);
                    lout_r <= {1'b0, i_cres} + 4'd1;
                    active_r <= 1'b0; sending_r <= 1'b0;
                  end else begin
                    active_r <= 1'b1; sending_r <= 1'b1;
                  end
                  // ceiling division, one quotient bit a cycle
                  rem_r <= (i_fsize == 24'd0) ? '0 : SB'(i_fsize) - SB'(1);
                  quo_r <= '0; dacc_r <= '0; dstep_r <= 6'(SB);
                  tot_r <= '0;
                  st_r <= ST_DIV;
                end
              end
              OP_TICK: begin
                if (active_r && sending_r) begin
                  if (nts_r < tot_r && (SB+1)'(nts_r) < wlim) begin
                    if (i_link == LINK_SEND_FAIL) begin
                      lout_r <= FR_IO; fin_r <= 1'b1; fres_r <= FR_IO; rs_r <= RS_ERR;
                      octx_r <= sctx_r; active_r <= 1'b0; sending_r <= 1'b0;
                      nts_r <= '0; idle_r <= '0; ret_r <= '0;
                    end else begin
                      cur_r <= nts_r; soff_r <= OB'(nts_r) * OB'(epay);
                      st_r <= ST_SEND_NEW;
                    end
                  end else st_r <= ST_ACK;
                end
              end
              OP_CANCEL: begin
                if (active_r) begin
                  fin_r <= 1'b1;
                  fres_r <= i_cok ? (i_abort ? FR_ABORTED : FR_CANCELLED) : FR_IO;
                  rs_r <= i_cok ? RS_BUSY : RS_ERR; octx_r <= sctx_r;
                  dup_r <= dup_big;
                  if (lout_r == FR_NONE)
                    lout_r <= i_cok ? (i_abort ? FR_ABORTED : FR_CANCELLED) : FR_IO;
                  active_r <= 1'b0; sending_r <= 1'b0;
                  nts_r <= '0; idle_r <= '0; ret_r <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (dstep_r == 6'd0) begin
            tot_r <= (fsz_r == '0) ? '0 : quo_r + SB'(1);
            st_r <= ST_STATUS;
          end else begin
            if ({dacc_r[SB-1:0], rem_r[SB-1]} >= (SB+1)'(epay)) begin
              dacc_r <= {dacc_r[SB-1:0], rem_r[SB-1]} - (SB+1)'(epay);
              quo_r <= {quo_r[SB-2:0], 1'b1};
            end else begin
              dacc_r <= {dacc_r[SB-1:0], rem_r[SB-1]};
              quo_r <= {quo_r[SB-2:0], 1'b0};
            end
            rem_r <= {rem_r[SB-2:0], 1'b0};
            dstep_r <= dstep_r - 6'd1;
          end
        end
        ST_SEND_NEW, ST_RESEND: begin
          if (o_free) begin
            o_full_r <= 1'b1; o_kind <= 1'b0; o_seg <= cur_r; o_off <= soff_r[SB-1:0];
            if (soff_r < OB'(fsz_r))
              o_len <= (rem_bytes > OB'(epay)) ? 13'(epay) : 13'(rem_bytes);
            else o_len <= '0;
            o_fin <= 1'b0; o_fres <= FR_NONE; o_rs <= RS_OK; o_ctx <= '0;
            o_prog <= 1'b0; o_dup <= 1'b0; o_rsd <= 1'b0;
            cur_r <= cur_r + SB'(1); soff_r <= soff_r + OB'(epay);
            if (st_r == ST_SEND_NEW) begin
              nts_r <= cur_r + SB'(1);
              if (!((cur_r + SB'(1)) < tot_r && (SB+1)'(cur_r + SB'(1)) < wlim))
                st_r <= ST_ACK;
            end else if ((cur_r + SB'(1)) >= lim_r) st_r <= ST_STATUS;
          end
        end
        ST_ACK: begin
          st_r <= ST_STATUS;
          if (ack_r < tot_r) begin
            if (i_link >= 2'd2) begin
              lout_r <= FR_IO; fin_r <= 1'b1; fres_r <= FR_IO; rs_r <= RS_ERR;
              octx_r <= sctx_r; active_r <= 1'b0; sending_r <= 1'b0;
              nts_r <= '0; idle_r <= '0; ret_r <= '0;
            end else begin
              ack_r <= ack_n; comm_r <= comm_n;
              dup_r <= dp_in > dcnt_r; dcnt_r <= dp_in;
              prog_r <= prog_n; idle_r <= idle_n;
              if (prog_n) ret_r <= '0;
              if (nts_r > ack_n && idle_n >= tmo_r) begin
                if ((prog_n ? 8'd0 : ret_r) >= bud_r) begin
                  fin_r <= 1'b1; fres_r <= i_cok ? FR_RETRY : FR_IO; rs_r <= RS_ERR;
                  octx_r <= sctx_r; prog_r <= 1'b0; rsd_r <= 1'b0;
                  dup_r <= i_cok && (i_adup > dp_in);
                  if (i_cok) lout_r <= FR_RETRY;
                  else if (lout_r == FR_NONE) lout_r <= FR_IO;
                  active_r <= 1'b0; sending_r <= 1'b0;
                  nts_r <= '0; idle_r <= '0; ret_r <= '0;
                end else begin
                  idle_r <= '0; ret_r <= (prog_n ? 8'd0 : ret_r) + 8'd1;
                  rtot_r <= rtot_r + 32'd1; rsd_r <= 1'b1;
                  cur_r <= ack_n; soff_r <= OB'(ack_n) * OB'(epay);
                  lim_r <= ((SB+1)'(ack_n) + (SB+1)'(ewin) > (SB+1)'(tot_r)) ? tot_r
                           : SB'((SB+1)'(ack_n) + (SB+1)'(ewin));
                  if (ack_n < tot_r) st_r <= ST_RESEND;
                  else fin_r <= 1'b1; // completes below
                end
              end
              if (ack_n == tot_r) fin_r <= 1'b1;
            end
          end else fin_r <= 1'b1;
        end
        ST_STATUS: begin
          // tick completion check happens here, after ack and resend
          if (o_free) begin
            o_full_r <= 1'b1; o_kind <= 1'b1; o_seg <= '0; o_off <= '0; o_len <= '0;
            o_prog <= prog_r; o_dup <= dup_r; o_rsd <= rsd_r;
            o_fin <= fin_r; o_fres <= fres_r; o_rs <= rs_r; o_ctx <= octx_r;
            if (fin_r && active_r && i_op == OP_TICK) begin
              o_fres <= i_cok ? {1'b0, i_cres} + 4'd1 : FR_IO;
              o_rs <= i_cok ? map_status(i_cres) : RS_ERR;
              o_ctx <= sctx_r;
              lout_r <= i_cok ? {1'b0, i_cres} + 4'd1 : FR_IO;
              active_r <= 1'b0; sending_r <= 1'b0;
              nts_r <= '0; idle_r <= '0; ret_r <= '0;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign q_take = (st_r == ST_STATUS) && o_free;

  logic unused_ok;
  assign unused_ok = ^{rtot_r, LINK_OK};
endmodule
`default_nettype wire

### design/go_back_n_sender_window.sv
`default_nettype none
// Channel | Dir | Beat content
// in      | in  | op, context, file size, link and ack poll, control reply
// out     | out | send command (kind 0) or status (kind 1, last 1)
// cfg     | in  | write enable, index, 24-bit data
// The segment count for a start comes from a one-bit-per-cycle divider. A
// tick issues its send commands, then checks the ack poll and may resend;
// the status beat follows the commands. Reset is synchronous and active
// low. A two-beat input queue and an output register let each side stall
// independently; a held output beat blocks the sequencer only.
module go_back_n_sender_window import gbn_pkg::*; #(
  parameter int MAX_WINDOW = DefMaxWindow,
  parameter int SIZE_BITS = DefSizeBits,
  parameter int MAX_PAYLOAD = DefMaxPayload
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_idx,
  input wire logic [23:0] cfg_wdata,
  gbn_if.sink in_ch,
  gbn_if.source out_ch
);
  localparam int IW = 149;
  logic q_valid, q_take;
  logic [IW-1:0] q;

  gbn_front #(.IW(IW)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_take, .q_data(q)
  );

  // in data layout, msb first: op ctx fsize range link ares acont acomm adup cok cres abort
  // out data layout, msb first: kind seg off len fin fres rs ctx prog dup rsd last
  gbn_engine #(.MAX_WINDOW(MAX_WINDOW), .SIZE_BITS(SIZE_BITS), .MAX_PAYLOAD(MAX_PAYLOAD))
  u_eng (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .q_valid, .q_take,
    .i_op(q[148:147]), .i_ctx(q[146:115]), .i_fsize(q[114:91]), .i_range(q[90]),
    .i_link(q[89:88]), .i_ares(q[87:85]), .i_acont(q[84:61]), .i_acomm(q[60:37]),
    .i_adup(q[36:5]), .i_cok(q[4]), .i_cres(q[3:1]), .i_abort(q[0]),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready),
    .o_kind(out_ch.data[104]), .o_seg(out_ch.data[103:80]), .o_off(out_ch.data[79:56]),
    .o_len(out_ch.data[55:43]), .o_fin(out_ch.data[42]), .o_fres(out_ch.data[41:38]),
    .o_rs(out_ch.data[37:36]), .o_ctx(out_ch.data[35:4]), .o_prog(out_ch.data[3]),
    .o_dup(out_ch.data[2]), .o_rsd(out_ch.data[1])
  );
  assign out_ch.data[0] = out_ch.data[104];
endmodule
`default_nettype wire

### design/gbn_checker.sv
`default_nettype none
module gbn_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic o_valid,
  input wire logic o_ready,
  input wire logic [104:0] o_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_data)) else $error("out held");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> o_data[0] == o_data[104]) else $error("last kind");
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_data[104] |-> o_data[42:1] == '0) else $error("cmd status");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_data[104] |-> o_data[103:43] == '0) else $error("status cmd");
endmodule
bind go_back_n_sender_window gbn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .o_valid(out_ch.valid), .o_ready(out_ch.ready),
  .o_data(out_ch.data)
);
`default_nettype wire
